[design/kbc_pkg.sv]
// ----------------------------------------------------------------------------
// Keyboard controller package
// Shared constants, codes and types of the PS/2 keyboard controller core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kbc_pkg;

  // Default output queue depth and translation table size.
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int XLATE_DEPTH     = 256;

  // Event kinds on the input channel.
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_SCAN  = 2'd2,
    KIND_LOAD  = 2'd3
  } kbc_kind_e;

  // I/O ports.
  localparam logic [15:0] PORT_DATA   = 16'h0060;
  localparam logic [15:0] PORT_SYSCTL = 16'h0061;
  localparam logic [15:0] PORT_CMD    = 16'h0064;
  localparam logic [7:0]  READ_UNMAPPED = 8'hFF;

  // Controller commands written to the command port.
  localparam logic [7:0] CCMD_READ_CMD  = 8'h20;
  localparam logic [7:0] CCMD_WRITE_CMD = 8'h60;
  localparam logic [7:0] CCMD_AUX_OFF   = 8'hA7;
  localparam logic [7:0] CCMD_AUX_ON    = 8'hA8;
  localparam logic [7:0] CCMD_KBD_OFF   = 8'hAD;
  localparam logic [7:0] CCMD_KBD_ON    = 8'hAE;
  localparam logic [7:0] CCMD_WRITE_OUT = 8'hD1;
  localparam logic [3:0] CCMD_PULSE_HI  = 4'hF;

  // Keyboard commands and responses.
  localparam logic [7:0] KCMD_SET_LEDS = 8'hED;
  localparam logic [7:0] KCMD_ECHO     = 8'hEE;
  localparam logic [7:0] KCMD_SCAN_SET = 8'hF0;
  localparam logic [7:0] KCMD_READ_ID  = 8'hF2;
  localparam logic [7:0] KCMD_ENABLE   = 8'hF4;
  localparam logic [7:0] KCMD_DISABLE  = 8'hF5;
  localparam logic [7:0] KCMD_NONE     = 8'h00;
  localparam logic [7:0] KRSP_ACK      = 8'hFA;
  localparam logic [7:0] KRSP_ERR      = 8'hFE;
  localparam logic [7:0] KRSP_ECHO     = 8'hEE;
  localparam logic [7:0] KRSP_ID1      = 8'h83;
  localparam logic [7:0] KRSP_ID2      = 8'hAB;
  localparam logic [7:0] SCAN_BREAK    = 8'hF0;
  localparam logic [7:0] BREAK_BIT     = 8'h80;

  // Command byte bit positions.
  localparam int CB_IRQ1    = 0;
  localparam int CB_SYSFLAG = 2;
  localparam int CB_IGNLOCK = 3;
  localparam int CB_KBD_OFF = 4;
  localparam int CB_AUX_OFF = 5;
  localparam int CB_XLATE   = 6;

  // Translation entries that keyboard responses use, kept in registers.
  localparam int KBC_SLOTS = 8;
  typedef enum logic [2:0] {
    SL_ACK  = 3'd0,
    SL_ERR  = 3'd1,
    SL_ECHO = 3'd2,
    SL_ID1  = 3'd3,
    SL_ID2  = 3'd4,
    SL_SET1 = 3'd5,
    SL_SET2 = 3'd6,
    SL_SET3 = 3'd7
  } kbc_slot_e;

  // Table index that each response slot mirrors.
  function automatic logic [7:0] slot_code(input kbc_slot_e slot);
    logic [7:0] code;
    case (slot)
      SL_ACK:  code = KRSP_ACK;
      SL_ERR:  code = KRSP_ERR;
      SL_ECHO: code = KRSP_ECHO;
      SL_ID1:  code = KRSP_ID1;
      SL_ID2:  code = KRSP_ID2;
      SL_SET1: code = 8'd1;
      SL_SET2: code = 8'd2;
      SL_SET3: code = 8'd3;
      default: code = KRSP_ACK;
    endcase
    return code;
  endfunction

  // Queue operation for one event: a pop or up to three pushes.
  typedef struct packed {
    logic            pop;
    logic [1:0]      push_n;
    logic [2:0][7:0] push_byte;
  } kbc_qop_t;

endpackage

[design/kbc_if.sv]
// ----------------------------------------------------------------------------
// Keyboard controller channels
// Valid/ready channels for events, results and the lock switch register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Event channel: bus accesses, scan bytes and table loads.
interface kbc_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] port;
  logic [7:0]  data;
  logic        last_of_sequence;
  logic [7:0]  table_index;

  modport source (output valid, kind, port, data, last_of_sequence, table_index,
                  input ready);
  modport sink (input valid, kind, port, data, last_of_sequence, table_index,
                output ready);
endinterface

// Result channel: one result per event.
interface kbc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq1;
  logic [7:0] leds;
  logic [1:0] scan_set_index;
  logic       reset_request;
  logic [4:0] queue_count;

  modport source (output valid, read_data, irq1, leds, scan_set_index, reset_request,
                  queue_count, input ready);
  modport sink (input valid, read_data, irq1, leds, scan_set_index, reset_request,
                queue_count, output ready);
endinterface

// Configuration channel: keyboard lock switch.
interface kbc_cfg_if;
  logic valid;
  logic ready;
  logic keyboard_lock;

  modport source (output valid, keyboard_lock, input ready);
  modport sink (input valid, keyboard_lock, output ready);
endinterface

[design/ps2_keyboard_controller_core.sv]
// ----------------------------------------------------------------------------
// PS/2 keyboard controller core
// Controller with attached keyboard model, driven one event at a time.
//
// Events arrive on evt_i: bus reads and writes at ports 0x60, 0x61 and 0x64,
// keyboard scan bytes, and loads into the scan code translation table. Each
// event gives exactly one result on res_o: read data, an irq1 pulse, a reset
// request pulse, and the LED byte, scan set and queue fill after the event.
// cfg_i writes the keyboard lock switch; it is always ready.
// An event is held in an input register, worked out in one pass of logic,
// and then moves into the result register that drives res_o. One event per
// cycle is sustained while res_o does not stall; the single compute stage
// between the two registers sets that rate. The table RAM read for a scan
// byte is issued at the transfer itself.
// When res_o stalls, the result register holds and the input register keeps
// the next event; once both are occupied, evt_i takes no further event until
// the result is transferred.
// Reset empties the queue and clears all controller and keyboard state; the
// translation table is undefined until loaded. No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ps2_keyboard_controller_core import kbc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kbc_evt_if.sink    evt_i,
  kbc_res_if.source  res_o,
  kbc_cfg_if.sink    cfg_i
);

  localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);

  // Handshake and input register.
  logic        evt_xfer;
  logic        s1_adv;
  logic        s1_valid_q;
  kbc_kind_e   s1_kind_q;
  logic [15:0] s1_port_q;
  logic [7:0]  s1_data_q;
  logic        s1_last_q;

  // Result register.
  logic       out_valid_q;
  logic [7:0] rd_q, rd_d;
  logic       irq_q, irq_d;
  logic       rst_req_q, rst_req_d;

  // Controller and keyboard state.
  logic [6:0] cmd_q, cmd_d;
  logic [7:0] ctrl_pend_q, ctrl_pend_d;
  logic [7:0] kbd_pend_q, kbd_pend_d;
  logic       iwc_q, iwc_d;
  logic       p61_q, p61_d;
  logic [7:0] led_q, led_d;
  logic [1:0] set_q, set_d;
  logic       bps_q, bps_d;
  logic       drop_q, drop_d;
  logic       lock_q;

  // Translation data.
  logic [7:0] shadow_q [KBC_SLOTS];
  logic [7:0] tab_rdata;

  // Queue.
  kbc_qop_t         qop, qop_raw;
  logic [7:0]       q_head;
  logic [LEN_W-1:0] q_len;
  logic             q_full;

  // Keyboard side results.
  logic [7:0]      kb_led, kb_pend;
  logic [1:0]      kb_set, kb_n;
  logic [2:0][7:0] kb_byte;
  logic [7:0]      ack_b, err_b, echo_b, id1_b, id2_b, setq_b;
  logic            xlate, inhib;
  kbc_slot_e       set_slot;

  assign evt_xfer    = evt_i.valid && evt_i.ready;
  assign s1_adv      = s1_valid_q && (!out_valid_q || res_o.ready);
  assign evt_i.ready = !s1_valid_q || s1_adv;
  assign cfg_i.ready = 1'b1;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (evt_i.ready) begin
      s1_valid_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_xfer) begin
      s1_kind_q <= kbc_kind_e'(evt_i.kind);
      s1_port_q <= evt_i.port;
      s1_data_q <= evt_i.data;
      s1_last_q <= evt_i.last_of_sequence;
    end
  end

  // Translation table; written and read at the event transfer.
  kbc_ram #(
    .WIDTH(8),
    .DEPTH(XLATE_DEPTH)
  ) u_xlate (
    .clk_i  (clk_i),
    .we_i   (evt_xfer && (evt_i.kind == KIND_LOAD)),
    .waddr_i(evt_i.table_index),
    .wdata_i(evt_i.data),
    .re_i   (evt_xfer),
    .raddr_i(evt_i.data),
    .rdata_o(tab_rdata)
  );

  // Register copies of the entries that keyboard responses translate through.
  always_ff @(posedge clk_i) begin
    if (evt_xfer && (evt_i.kind == KIND_LOAD)) begin
      for (int s = 0; s < KBC_SLOTS; s++) begin
        if (evt_i.table_index == slot_code(kbc_slot_e'(s))) begin
          shadow_q[3'(s)] <= evt_i.data;
        end
      end
    end
  end

  // Lock switch register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q <= 1'b0;
    end else if (cfg_i.valid) begin
      lock_q <= cfg_i.keyboard_lock;
    end
  end

  assign xlate  = cmd_q[CB_XLATE];
  assign inhib  = cmd_q[CB_KBD_OFF] || (lock_q && !cmd_q[CB_IGNLOCK]);
  assign q_full = (q_len == LEN_W'(QUEUE_DEPTH));

  // Response bytes as they enter the queue, translated or raw.
  always_comb begin
    case (set_q)
      2'd0:    set_slot = SL_SET1;
      2'd1:    set_slot = SL_SET2;
      default: set_slot = SL_SET3;
    endcase
  end

  assign ack_b  = xlate ? shadow_q[SL_ACK]  : KRSP_ACK;
  assign err_b  = xlate ? shadow_q[SL_ERR]  : KRSP_ERR;
  assign echo_b = xlate ? shadow_q[SL_ECHO] : KRSP_ECHO;
  assign id1_b  = xlate ? shadow_q[SL_ID1]  : KRSP_ID1;
  assign id2_b  = xlate ? shadow_q[SL_ID2]  : KRSP_ID2;
  assign setq_b = xlate ? shadow_q[set_slot] : (8'(set_q) + 8'd1);

  // Keyboard command handling for a byte written to the data port.
  always_comb begin
    kb_led  = led_q;
    kb_set  = set_q;
    kb_pend = s1_data_q;
    kb_n    = 2'd1;
    kb_byte = '0;
    if (kbd_pend_q == KCMD_SET_LEDS) begin
      kb_led     = s1_data_q;
      kb_pend    = KCMD_NONE;
      kb_byte[0] = ack_b;
    end else if (kbd_pend_q == KCMD_SCAN_SET) begin
      kb_pend = KCMD_NONE;
      if (s1_data_q == 8'd0) begin
        kb_n       = 2'd2;
        kb_byte[0] = ack_b;
        kb_byte[1] = setq_b;
      end else if (s1_data_q <= 8'd3) begin
        kb_set     = s1_data_q[1:0] - 2'd1;
        kb_byte[0] = ack_b;
      end else begin
        kb_byte[0] = err_b;
      end
    end else begin
      case (s1_data_q)
        KCMD_SET_LEDS, KCMD_SCAN_SET, KCMD_ENABLE, KCMD_DISABLE: begin
          kb_byte[0] = ack_b;
        end
        KCMD_ECHO: begin
          kb_byte[0] = echo_b;
        end
        KCMD_READ_ID: begin
          kb_n       = 2'd3;
          kb_byte[0] = ack_b;
          kb_byte[1] = id1_b;
          kb_byte[2] = id2_b;
        end
        default: begin
          kb_byte[0] = err_b;
        end
      endcase
    end
  end

  // Event processing.
  always_comb begin
    cmd_d       = cmd_q;
    ctrl_pend_d = ctrl_pend_q;
    kbd_pend_d  = kbd_pend_q;
    iwc_d       = iwc_q;
    p61_d       = p61_q;
    led_d       = led_q;
    set_d       = set_q;
    bps_d       = bps_q;
    drop_d      = drop_q;
    rd_d        = '0;
    irq_d       = 1'b0;
    rst_req_d   = 1'b0;
    qop_raw     = '0;
    case (s1_kind_q)
      KIND_READ: begin
        if (s1_port_q == PORT_DATA) begin
          rd_d        = (q_len != '0) ? q_head : 8'd0;
          qop_raw.pop = 1'b1;
        end else if (s1_port_q == PORT_SYSCTL) begin
          p61_d = !p61_q;
          rd_d  = {3'b000, !p61_q, 4'b0000};
        end else if (s1_port_q == PORT_CMD) begin
          rd_d = {3'b000, lock_q, iwc_q, cmd_q[CB_SYSFLAG], 1'b0, (q_len != '0)};
        end else begin
          rd_d = READ_UNMAPPED;
        end
      end
      KIND_WRITE: begin
        if (s1_port_q == PORT_DATA) begin
          iwc_d = 1'b0;
          if (ctrl_pend_q == CCMD_WRITE_CMD) begin
            cmd_d       = s1_data_q[6:0];
            ctrl_pend_d = KCMD_NONE;
          end else if (ctrl_pend_q == CCMD_WRITE_OUT) begin
            ctrl_pend_d = KCMD_NONE;
          end else begin
            led_d      = kb_led;
            set_d      = kb_set;
            kbd_pend_d = kb_pend;
            if (!inhib) begin
              qop_raw.push_n    = kb_n;
              qop_raw.push_byte = kb_byte;
              irq_d             = cmd_q[CB_IRQ1];
            end
          end
        end else if (s1_port_q == PORT_CMD) begin
          iwc_d       = 1'b1;
          ctrl_pend_d = s1_data_q;
          case (s1_data_q)
            CCMD_READ_CMD: begin
              qop_raw.push_n       = 2'd1;
              qop_raw.push_byte[0] = {1'b0, cmd_q};
            end
            CCMD_AUX_OFF: cmd_d[CB_AUX_OFF] = 1'b1;
            CCMD_AUX_ON:  cmd_d[CB_AUX_OFF] = 1'b0;
            CCMD_KBD_OFF: cmd_d[CB_KBD_OFF] = 1'b1;
            CCMD_KBD_ON:  cmd_d[CB_KBD_OFF] = 1'b0;
            default: begin
              rst_req_d = (s1_data_q[7:4] == CCMD_PULSE_HI) && !s1_data_q[0];
            end
          endcase
        end
      end
      KIND_SCAN: begin
        if (!inhib) begin
          if (!drop_q) begin
            if (q_full) begin
              drop_d = 1'b1;
            end else if (xlate) begin
              if (bps_q) begin
                bps_d                = 1'b0;
                qop_raw.push_n       = 2'd1;
                qop_raw.push_byte[0] = tab_rdata | BREAK_BIT;
              end else if (s1_data_q == SCAN_BREAK) begin
                bps_d = 1'b1;
              end else begin
                qop_raw.push_n       = 2'd1;
                qop_raw.push_byte[0] = tab_rdata;
              end
            end else begin
              qop_raw.push_n       = 2'd1;
              qop_raw.push_byte[0] = s1_data_q;
            end
          end
          irq_d = s1_last_q && cmd_q[CB_IRQ1];
        end
        // The end of a sequence always drops a dangling prefix and drop state.
        if (s1_last_q) begin
          bps_d  = 1'b0;
          drop_d = 1'b0;
        end
      end
      default: begin
        // Table loads are done at the transfer.
      end
    endcase
  end

  assign qop = s1_adv ? qop_raw : '0;

  kbc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .op_i  (qop),
    .head_o(q_head),
    .len_o (q_len)
  );

  // State commits when the event leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= '0;
      ctrl_pend_q <= '0;
      kbd_pend_q  <= '0;
      iwc_q       <= 1'b0;
      p61_q       <= 1'b0;
      led_q       <= '0;
      set_q       <= '0;
      bps_q       <= 1'b0;
      drop_q      <= 1'b0;
    end else if (s1_adv) begin
      cmd_q       <= cmd_d;
      ctrl_pend_q <= ctrl_pend_d;
      kbd_pend_q  <= kbd_pend_d;
      iwc_q       <= iwc_d;
      p61_q       <= p61_d;
      led_q       <= led_d;
      set_q       <= set_d;
      bps_q       <= bps_d;
      drop_q      <= drop_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      rd_q      <= rd_d;
      irq_q     <= irq_d;
      rst_req_q <= rst_req_d;
    end
  end

  // State only moves together with the result register, so the LED byte,
  // scan set and queue fill are read straight from their registers.
  assign res_o.valid          = out_valid_q;
  assign res_o.read_data      = rd_q;
  assign res_o.irq1           = irq_q;
  assign res_o.reset_request  = rst_req_q;
  assign res_o.leds           = led_q;
  assign res_o.scan_set_index = set_q;
  assign res_o.queue_count    = 5'(q_len);

endmodule

[design/kbc_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/kbc_queue.sv]
// ----------------------------------------------------------------------------
// Keyboard controller output queue
// Shifting byte queue: pops at the head, takes up to three bytes at the tail.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kbc_queue import kbc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  localparam int LEN_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kbc_qop_t         op_i,
  output logic [7:0]       head_o,
  output logic [LEN_W-1:0] len_o
);

  logic [7:0]       ent_q [DEPTH];
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] free;
  logic [1:0]       take;

  // Bytes that still fit; the rest of a push is dropped.
  assign free = LEN_W'(DEPTH) - len_q;
  assign take = (LEN_W'(op_i.push_n) > free) ? free[1:0] : op_i.push_n;

  always_comb begin
    if (op_i.pop && (len_q != '0)) begin
      len_d = len_q - LEN_W'(1);
    end else begin
      len_d = len_q + LEN_W'(take);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  // Each entry either shifts from its upper neighbor or takes a pushed byte.
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_entry
    localparam logic [LEN_W-1:0] IDX = LEN_W'(gi);
    logic [7:0]       upper;
    logic [LEN_W-1:0] off;
    logic             wr;

    if (gi < DEPTH - 1) begin : g_mid
      assign upper = ent_q[gi+1];
    end else begin : g_top
      assign upper = ent_q[gi];
    end

    assign off = IDX - len_q;
    assign wr  = (IDX >= len_q) && (off < LEN_W'(take));

    always_ff @(posedge clk_i) begin
      if (op_i.pop) begin
        ent_q[gi] <= upper;
      end else if (wr) begin
        ent_q[gi] <= op_i.push_byte[off[1:0]];
      end
    end
  end

  assign head_o = ent_q[0];
  assign len_o  = len_q;

endmodule

[design/kbc_checker.sv]
// ----------------------------------------------------------------------------
// Keyboard controller checker
// Assertions on the result channel of the controller core, bound to it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kbc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [7:0] res_read_data_i,
  input logic       res_irq1_i,
  input logic       res_reset_request_i,
  input logic [4:0] res_queue_count_i
);

  logic       res_xfer;
  logic       have_prev_q;
  logic [4:0] prev_cnt_q;
  logic [4:0] cnt_step;

  assign res_xfer = res_valid_i && res_ready_i;
  assign cnt_step = res_queue_count_i - prev_cnt_q;

  // Queue fill of the previous transferred result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      prev_cnt_q  <= '0;
    end else if (res_xfer) begin
      have_prev_q <= 1'b1;
      prev_cnt_q  <= res_queue_count_i;
    end
  end

  // A result waiting on the receiver stays offered.
  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> res_valid_i)
    else $error("result withdrawn before transfer");

  // A waiting result keeps its read data.
  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> $stable(res_read_data_i))
    else $error("result read data changed while stalled");

  // Interrupt and reset pulses come from writes or scan bytes, never from reads.
  a_pulse_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && (res_irq1_i || res_reset_request_i)) |->
      (!(res_irq1_i && res_reset_request_i) && (res_read_data_i == 8'd0)))
    else $error("pulse on a read or both pulses together");

  // One event adds at most three queue bytes or removes one.
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_xfer && have_prev_q) |->
      ((cnt_step == 5'd0) || (cnt_step == 5'd1) || (cnt_step == 5'd2) ||
       (cnt_step == 5'd3) || (cnt_step == 5'd31)))
    else $error("queue fill moved by an impossible step");

endmodule

bind ps2_keyboard_controller_core kbc_checker u_kbc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .res_valid_i        (res_o.valid),
  .res_ready_i        (res_o.ready),
  .res_read_data_i    (res_o.read_data),
  .res_irq1_i         (res_o.irq1),
  .res_reset_request_i(res_o.reset_request),
  .res_queue_count_i  (res_o.queue_count)
);

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Keyboard controller core testbench
// Sends bus accesses, scan byte sequences and translation table loads into
// the core in random bursts while the result side stalls on patterns of its
// own. Each result is compared against a behavioral copy of the controller
// and its keyboard. The run covers both lock switch settings over several
// phases, and it holds the result side off long enough to back up the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import kbc_pkg::*;

  localparam int QDEPTH           = QUEUE_DEPTH_DEF;
  localparam int RESULT_LATENCY   = 4;
  localparam int PHASES           = 6;
  localparam int EVENTS_PER_PHASE = 120;
  localparam logic [PHASES-1:0] LOCK_PLAN = 6'b011010;
  localparam int RUN_LIMIT_NS     = 3_000_000;
  localparam logic [7:0] CCMD_NONE     = 8'h00;
  localparam logic [7:0] SYSCTL_TOGGLE = 8'h10;
  localparam logic [7:0] SCAN_EXT      = 8'hE0;
  localparam int SCAN_SETS             = 3;

  typedef struct {
    kbc_kind_e   kind;
    logic [15:0] port;
    logic [7:0]  data;
    logic        last;
    logic [7:0]  tidx;
  } kbc_event_t;

  typedef struct {
    logic [7:0] read_data;
    logic       irq1;
    logic [7:0] leds;
    logic [1:0] scan_set_index;
    logic       reset_request;
    logic [4:0] queue_count;
  } kbc_result_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_PERIODIC,
    RX_COIN
  } rx_pattern_e;

  logic clk_i;
  logic rst_ni;

  kbc_evt_if evt ();
  kbc_res_if res ();
  kbc_cfg_if cfg ();

  ps2_keyboard_controller_core #(
    .QUEUE_DEPTH(QDEPTH)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .evt_i (evt),
    .res_o (res),
    .cfg_i (cfg)
  );

  // Controller and keyboard state as the behavioral copy sees it.
  logic [7:0] fifo_bytes[$];
  logic [7:0] ctrl_cmd;
  logic [7:0] kbd_cmd;
  logic [6:0] cmd_byte;
  logic       in_cmd_flag;
  logic [7:0] sysctl_byte;
  logic [7:0] led_byte;
  logic [1:0] set_sel;
  logic [7:0] xlate_map[XLATE_DEPTH];
  logic       break_pending;
  logic       drop_seq;
  logic       lock_switch;

  // Stimulus and checking bookkeeping.
  kbc_event_t  event_queue[$];
  kbc_result_t awaited_responses[$];
  int events_queued;
  int events_accepted;
  int ignored_events;
  int results_checked;
  int mismatches;
  int reads_seen;
  int writes_seen;
  int scans_seen;
  int loads_seen;
  logic evt_taken;
  logic rx_hold;
  logic pressure_armed;

  // Sender burst and receiver stall state.
  int burst_left;
  int gap_left;
  int stall_left;
  rx_pattern_e stall_mode;

  // ------------------------------------------------------------------------
  // Behavioral copy of the controller
  // ------------------------------------------------------------------------

  function automatic void reset_model();
    fifo_bytes.delete();
    ctrl_cmd      = CCMD_NONE;
    kbd_cmd       = KCMD_NONE;
    cmd_byte      = '0;
    in_cmd_flag   = 1'b0;
    sysctl_byte   = '0;
    led_byte      = '0;
    set_sel       = '0;
    break_pending = 1'b0;
    drop_seq      = 1'b0;
    lock_switch   = 1'b0;
  endfunction

  function automatic logic kbd_inhibited();
    return cmd_byte[CB_KBD_OFF] || (lock_switch && !cmd_byte[CB_IGNLOCK]);
  endfunction

  // A byte that finds the queue full is lost.
  function automatic void fifo_push(input logic [7:0] b);
    if (fifo_bytes.size() < QDEPTH) fifo_bytes.push_back(b);
  endfunction

  // Keyboard answer of up to three bytes, low byte first; returns the irq1 pulse.
  function automatic logic kbd_respond(input int count, input logic [2:0][7:0] bytes);
    if (kbd_inhibited()) return 1'b0;
    for (int i = 0; i < count; i++) begin
      fifo_push(cmd_byte[CB_XLATE] ? xlate_map[bytes[i]] : bytes[i]);
    end
    return cmd_byte[CB_IRQ1];
  endfunction

  // A byte written to the data port that goes on to the keyboard.
  function automatic logic kbd_accept(input logic [7:0] b);
    logic [7:0] set_code;
    if (kbd_cmd == KCMD_SET_LEDS) begin
      led_byte = b;
      kbd_cmd  = KCMD_NONE;
      return kbd_respond(1, {16'h0000, KRSP_ACK});
    end
    if (kbd_cmd == KCMD_SCAN_SET) begin
      kbd_cmd = KCMD_NONE;
      // Zero asks for the current set; 1 to 3 select one.
      if (b == 8'h00) begin
        set_code = {6'b000000, set_sel} + 8'd1;
        return kbd_respond(2, {8'h00, set_code, KRSP_ACK});
      end
      if (b <= SCAN_SETS) begin
        set_sel = 2'(b - 8'd1);
        return kbd_respond(1, {16'h0000, KRSP_ACK});
      end
      return kbd_respond(1, {16'h0000, KRSP_ERR});
    end
    kbd_cmd = b;
    case (b)
      KCMD_SET_LEDS, KCMD_SCAN_SET, KCMD_ENABLE, KCMD_DISABLE:
        return kbd_respond(1, {16'h0000, KRSP_ACK});
      KCMD_ECHO:
        return kbd_respond(1, {16'h0000, KRSP_ECHO});
      KCMD_READ_ID:
        return kbd_respond(3, {KRSP_ID2, KRSP_ID1, KRSP_ACK});
      default:
        return kbd_respond(1, {16'h0000, KRSP_ERR});
    endcase
  endfunction

  // One scan byte from a keyboard that is not inhibited.
  function automatic void scan_accept(input logic [7:0] b);
    if (drop_seq) return;
    if (fifo_bytes.size() >= QDEPTH) begin
      drop_seq = 1'b1;
      return;
    end
    if (cmd_byte[CB_XLATE]) begin
      if (break_pending) begin
        break_pending = 1'b0;
        fifo_push(xlate_map[b] | BREAK_BIT);
      end else if (b == SCAN_BREAK) begin
        break_pending = 1'b1;
      end else begin
        fifo_push(xlate_map[b]);
      end
    end else begin
      fifo_push(b);
    end
  endfunction

  // Advances the copy by one event and returns the result the core must give.
  function automatic kbc_result_t controller_response(input kbc_event_t ev);
    kbc_result_t r;
    r.read_data     = '0;
    r.irq1          = 1'b0;
    r.reset_request = 1'b0;
    case (ev.kind)
      KIND_READ: begin
        if (ev.port == PORT_DATA) begin
          if (fifo_bytes.size() != 0) r.read_data = fifo_bytes.pop_front();
        end else if (ev.port == PORT_SYSCTL) begin
          sysctl_byte ^= SYSCTL_TOGGLE;
          r.read_data  = sysctl_byte;
        end else if (ev.port == PORT_CMD) begin
          r.read_data = {3'b000, lock_switch, in_cmd_flag, cmd_byte[CB_SYSFLAG], 1'b0,
                         fifo_bytes.size() != 0};
        end else begin
          r.read_data = READ_UNMAPPED;
        end
      end
      KIND_WRITE: begin
        if (ev.port == PORT_DATA) begin
          in_cmd_flag = 1'b0;
          if (ctrl_cmd == CCMD_WRITE_CMD) begin
            cmd_byte = ev.data[6:0];
            ctrl_cmd = CCMD_NONE;
          end else if (ctrl_cmd == CCMD_WRITE_OUT) begin
            ctrl_cmd = CCMD_NONE;
          end else begin
            r.irq1 = kbd_accept(ev.data);
          end
        end else if (ev.port == PORT_CMD) begin
          in_cmd_flag = 1'b1;
          ctrl_cmd    = ev.data;
          case (ev.data)
            CCMD_READ_CMD: fifo_push({1'b0, cmd_byte});
            CCMD_AUX_OFF:  cmd_byte[CB_AUX_OFF] = 1'b1;
            CCMD_AUX_ON:   cmd_byte[CB_AUX_OFF] = 1'b0;
            CCMD_KBD_OFF:  cmd_byte[CB_KBD_OFF] = 1'b1;
            CCMD_KBD_ON:   cmd_byte[CB_KBD_OFF] = 1'b0;
            default: begin
              // Output port pulse commands with the reset line driven low.
              if (ev.data[7:4] == CCMD_PULSE_HI && !ev.data[0]) r.reset_request = 1'b1;
            end
          endcase
        end
      end
      KIND_SCAN: begin
        if (!kbd_inhibited()) begin
          scan_accept(ev.data);
          if (ev.last && cmd_byte[CB_IRQ1]) r.irq1 = 1'b1;
        end
        if (ev.last) begin
          break_pending = 1'b0;
          drop_seq      = 1'b0;
        end
      end
      default: xlate_map[ev.tidx] = ev.data;
    endcase
    r.leds           = led_byte;
    r.scan_set_index = set_sel;
    r.queue_count    = 5'(fifo_bytes.size());
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Stimulus building
  // ------------------------------------------------------------------------

  function automatic void queue_event(input kbc_kind_e kind, input logic [15:0] port,
                                      input logic [7:0] data, input logic last,
                                      input logic [7:0] tidx);
    kbc_event_t ev;
    ev.kind = kind;
    ev.port = port;
    ev.data = data;
    ev.last = last;
    ev.tidx = tidx;
    event_queue.push_back(ev);
    events_queued++;
  endfunction

  // Fields an event kind does not use carry random values.
  function automatic void send_read(input logic [15:0] port);
    queue_event(KIND_READ, port, 8'($urandom), 1'($urandom), 8'($urandom));
  endfunction

  function automatic void send_write(input logic [15:0] port, input logic [7:0] data);
    queue_event(KIND_WRITE, port, data, 1'($urandom), 8'($urandom));
  endfunction

  function automatic void send_scan(input logic [7:0] data, input logic last);
    queue_event(KIND_SCAN, 16'($urandom), data, last, 8'($urandom));
  endfunction

  function automatic void send_load(input logic [7:0] idx, input logic [7:0] data);
    queue_event(KIND_LOAD, 16'($urandom), data, 1'($urandom), idx);
  endfunction

  // One make or break sequence, sometimes extended, sometimes malformed.
  function automatic void add_key_sequence();
    logic [7:0] code;
    int shape;
    shape = $urandom_range(0, 9);
    do code = 8'($urandom); while (code == SCAN_BREAK);
    if (shape < 8 && $urandom_range(0, 3) == 0) send_scan(SCAN_EXT, 1'b0);
    if (shape >= 4 && shape < 8) send_scan(SCAN_BREAK, 1'b0);
    if (shape < 8) begin
      send_scan(code, 1'b1);
    end else if (shape == 8) begin
      // A break prefix that ends the sequence on its own.
      send_scan(SCAN_BREAK, 1'b1);
    end else begin
      repeat ($urandom_range(1, 3)) send_scan(8'($urandom), 1'b0);
      send_scan(8'($urandom), 1'b1);
    end
  endfunction

  // One randomly chosen piece of host or keyboard activity.
  function automatic void add_scenario();
    logic [7:0] v;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      add_key_sequence();
    end else if (pick < 45) begin
      repeat ($urandom_range(1, 5)) send_read(PORT_DATA);
      send_read(PORT_CMD);
    end else if (pick < 56) begin
      // Keyboard command, its parameter where it takes one, then the answer.
      case ($urandom_range(0, 6))
        0: v = KCMD_SET_LEDS;
        1: v = KCMD_ECHO;
        2: v = KCMD_SCAN_SET;
        3: v = KCMD_READ_ID;
        4: v = KCMD_ENABLE;
        5: v = KCMD_DISABLE;
        default: v = 8'($urandom);
      endcase
      send_write(PORT_DATA, v);
      if (v == KCMD_SET_LEDS) begin
        send_write(PORT_DATA, 8'($urandom));
      end else if (v == KCMD_SCAN_SET) begin
        send_write(PORT_DATA, ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(0, SCAN_SETS)));
      end
      repeat ($urandom_range(1, 4)) send_read(PORT_DATA);
    end else if (pick < 64) begin
      // New command byte; keep the keyboard clock running most of the time.
      v = 8'($urandom);
      if ($urandom_range(0, 3) != 0) v[CB_KBD_OFF] = 1'b0;
      send_write(PORT_CMD, CCMD_WRITE_CMD);
      send_write(PORT_DATA, v);
    end else if (pick < 68) begin
      send_write(PORT_CMD, CCMD_READ_CMD);
      send_read(PORT_DATA);
    end else if (pick < 76) begin
      case ($urandom_range(0, 7))
        0, 1: send_write(PORT_CMD, CCMD_KBD_ON);
        2: send_write(PORT_CMD, CCMD_KBD_OFF);
        3: send_write(PORT_CMD, CCMD_AUX_ON);
        4: send_write(PORT_CMD, CCMD_AUX_OFF);
        5: begin
          send_write(PORT_CMD, CCMD_WRITE_OUT);
          send_write(PORT_DATA, 8'($urandom));
        end
        6: send_write(PORT_CMD, {CCMD_PULSE_HI, 4'($urandom)});
        default: send_write(PORT_CMD, 8'($urandom));
      endcase
    end else if (pick < 81) begin
      case ($urandom_range(0, 2))
        0: send_read(PORT_SYSCTL);
        1: send_write(PORT_SYSCTL, 8'($urandom));
        default: send_read(16'($urandom));
      endcase
    end else if (pick < 85) begin
      send_load(8'($urandom), 8'($urandom));
    end else if (pick < 88) begin
      // Fill the queue so that the last sequence is cut short, then drain.
      repeat ($urandom_range(14, 20)) add_key_sequence();
      send_scan(SCAN_BREAK, 1'b0);
      send_scan(8'($urandom_range(0, 127)), 1'b1);
      repeat ($urandom_range(4, 18)) send_read(PORT_DATA);
    end else begin
      repeat ($urandom_range(1, 3)) begin
        queue_event(kbc_kind_e'($urandom_range(0, 3)),
                    ($urandom_range(0, 1) != 0) ? 16'($urandom) : PORT_DATA,
                    8'($urandom), 1'($urandom), 8'($urandom));
        ignored_events++;
      end
    end
  endfunction

  // Short fixed walk through the main operations and corner cases.
  function automatic void add_directed();
    send_read(PORT_DATA);
    send_read(PORT_CMD);
    send_read(PORT_SYSCTL);
    send_read(16'h0000);
    send_read(16'hFFFF);
    // Translation on, irq1 enabled, system flag set.
    send_write(PORT_CMD, CCMD_WRITE_CMD);
    send_write(PORT_DATA, 8'h45);
    send_write(PORT_CMD, CCMD_READ_CMD);
    send_read(PORT_DATA);
    send_write(PORT_DATA, KCMD_SET_LEDS);
    send_write(PORT_DATA, 8'hFF);
    send_write(PORT_DATA, KCMD_READ_ID);
    send_scan(SCAN_BREAK, 1'b0);
    send_scan(8'h1C, 1'b1);
    send_scan(SCAN_BREAK, 1'b1);
    send_write(PORT_DATA, KCMD_SCAN_SET);
    send_write(PORT_DATA, 8'h00);
    send_write(PORT_DATA, KCMD_ECHO);
    send_write(PORT_CMD, CCMD_KBD_OFF);
    send_scan(8'h00, 1'b1);
    send_write(PORT_CMD, CCMD_KBD_ON);
    send_write(PORT_CMD, 8'hFE);
    send_write(PORT_CMD, CCMD_WRITE_OUT);
    send_write(PORT_DATA, 8'h00);
    send_write(PORT_SYSCTL, 8'hFF);
    repeat (4) send_read(PORT_DATA);
  endfunction

  // ------------------------------------------------------------------------
  // Clock, idle waits and lock switch writes
  // ------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Waits until every queued event has been taken and answered.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (events_accepted != events_queued || awaited_responses.size() != 0);
    repeat (RESULT_LATENCY) @(negedge clk_i);
  endtask

  task automatic write_lock(input logic value);
    @(negedge clk_i);
    cfg.valid         <= 1'b1;
    cfg.keyboard_lock <= value;
    do @(posedge clk_i); while (!cfg.ready);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // Event driver: bursts of random length with random gaps in between
  // ------------------------------------------------------------------------

  always @(negedge clk_i) begin
    kbc_event_t item;
    if (rst_ni && (!evt.valid || evt_taken)) begin
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (burst_left != 0 && event_queue.size() != 0) begin
        item = event_queue.pop_front();
        evt.kind             <= item.kind;
        evt.port             <= item.port;
        evt.data             <= item.data;
        evt.last_of_sequence <= item.last;
        evt.table_index      <= item.tidx;
        evt.valid            <= 1'b1;
        burst_left--;
      end else begin
        evt.valid <= 1'b0;
        if (burst_left == 0) gap_left--;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Result side: stall patterns plus the long hold-offs below
  // ------------------------------------------------------------------------

  always @(negedge clk_i) begin
    logic take;
    if (stall_left == 0) begin
      stall_mode = rx_pattern_e'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 80);
    end
    stall_left--;
    case (stall_mode)
      RX_ALWAYS:   take = 1'b1;
      RX_MOSTLY:   take = ($urandom_range(0, 3) != 0);
      RX_PERIODIC: take = (stall_left % 3 != 0);
      default:     take = 1'($urandom);
    endcase
    res.ready <= take && !rx_hold;
  end

  // Long hold-offs while the sender keeps offering, so the core backs up.
  initial begin
    rx_hold = 1'b0;
    wait (pressure_armed);
    repeat (3) begin
      repeat ($urandom_range(20, 120)) @(posedge clk_i);
      rx_hold = 1'b1;
      repeat ($urandom_range(40, 90)) @(posedge clk_i);
      rx_hold = 1'b0;
    end
  end

  // ------------------------------------------------------------------------
  // Monitor: predicts on each event transfer, checks each result transfer
  // ------------------------------------------------------------------------

  function automatic int check_field(input string field, input logic [7:0] want,
                                     input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%02h, got 0x%02h", field, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i) begin
    kbc_event_t  ev;
    kbc_result_t want;
    evt_taken = 1'b0;
    if (rst_ni) begin
      if (cfg.valid && cfg.ready) lock_switch = cfg.keyboard_lock;
      // Results come from earlier events, so check before predicting.
      if (res.valid && res.ready) begin
        if (awaited_responses.size() == 0) begin
          $error("result transfer with no event waiting for it");
          mismatches++;
        end else begin
          want = awaited_responses.pop_front();
          mismatches += check_field("read_data", want.read_data, res.read_data);
          mismatches += check_field("irq1", 8'(want.irq1), 8'(res.irq1));
          mismatches += check_field("leds", want.leds, res.leds);
          mismatches += check_field("scan_set_index", 8'(want.scan_set_index),
                                    8'(res.scan_set_index));
          mismatches += check_field("reset_request", 8'(want.reset_request),
                                    8'(res.reset_request));
          mismatches += check_field("queue_count", 8'(want.queue_count),
                                    8'(res.queue_count));
          results_checked++;
        end
      end
      if (evt.valid && evt.ready) begin
        ev.kind = kbc_kind_e'(evt.kind);
        ev.port = evt.port;
        ev.data = evt.data;
        ev.last = evt.last_of_sequence;
        ev.tidx = evt.table_index;
        awaited_responses.push_back(controller_response(ev));
        evt_taken = 1'b1;
        events_accepted++;
        case (ev.kind)
          KIND_READ:  reads_seen++;
          KIND_WRITE: writes_seen++;
          KIND_SCAN:  scans_seen++;
          default:    loads_seen++;
        endcase
      end
    end
  end

  // ------------------------------------------------------------------------
  // Test sequence
  // ------------------------------------------------------------------------

  initial begin
    evt.valid            = 1'b0;
    evt.kind             = KIND_READ;
    evt.port             = '0;
    evt.data             = '0;
    evt.last_of_sequence = 1'b0;
    evt.table_index      = '0;
    cfg.valid            = 1'b0;
    cfg.keyboard_lock    = 1'b0;
    res.ready            = 1'b0;
    evt_taken            = 1'b0;
    pressure_armed       = 1'b0;
    burst_left           = 0;
    gap_left             = 0;
    stall_left           = 0;
    stall_mode           = RX_ALWAYS;
    events_queued        = 0;
    events_accepted      = 0;
    ignored_events       = 0;
    results_checked      = 0;
    mismatches           = 0;
    reads_seen           = 0;
    writes_seen          = 0;
    scans_seen           = 0;
    loads_seen           = 0;
    reset_model();

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Load the whole table first so no translation reads an unloaded entry.
    write_lock(1'b0);
    for (int i = 0; i < XLATE_DEPTH; i++) send_load(8'(i), 8'($urandom));
    add_directed();
    wait_idle();

    // Random phases, each with its own lock switch setting.
    for (int p = 0; p < PHASES; p++) begin
      int goal;
      write_lock(LOCK_PLAN[p]);
      goal = events_queued - ignored_events + EVENTS_PER_PHASE;
      pressure_armed = 1'b1;
      while (events_queued - ignored_events < goal) add_scenario();
      wait_idle();
    end

    $display("Covered %0d events: %0d bus reads, %0d bus writes, %0d scan bytes, %0d loads.",
             events_accepted, reads_seen, writes_seen, scans_seen, loads_seen);
    $display("Checked %0d results over %0d lock switch phases; %0d field mismatches.",
             results_checked, PHASES + 1, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #(RUN_LIMIT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
